>>> rtl/core/rtpt_pkg.sv
// Package for the region transition pattern table: sizes, operation codes,
// configuration indices and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtpt_pkg;
    localparam int RTPT_ENTRIES = 256;
    localparam int RTPT_WAYS    = 8;
    localparam int REGION_BLK   = 64;
    localparam int KEY_W        = 18;
    localparam int CONF_W       = 4;

    localparam logic [1:0] KIND_LOOKUP   = 2'd0;
    localparam logic [1:0] KIND_UPDATE   = 2'd1;
    localparam logic [1:0] KIND_PENALIZE = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    localparam logic CFG_MAX_CONF  = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    localparam logic [CONF_W-1:0] MAX_CONF_RST  = 4'd3;
    localparam logic [CONF_W-1:0] THRESHOLD_RST = 4'd2;
endpackage
`default_nettype wire

>>> rtl/core/rtpt_popcnt.sv
// Bit counter for overlap and union of two 64-block patterns.
// Counts one 16-bit slice per cycle; depends on rtpt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtpt_popcnt
    import rtpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic            done,
    output logic [6:0]      overlap,
    output logic [6:0]      union_cnt
);
    logic [2:0]  step_reg;
    logic        busy_reg;
    logic [6:0]  ov_reg, un_reg;
    logic [15:0] sa, sb;
    logic [4:0]  ov_s, un_s;

    always_comb
    begin
        sa = a[step_reg[1:0]*16 +: 16];
        sb = b[step_reg[1:0]*16 +: 16];
        ov_s = '0;
        un_s = '0;
        for (int i = 0; i < 16; i++)
        begin
            ov_s = ov_s + 5'(sa[i] & sb[i]);
            un_s = un_s + 5'(sa[i] | sb[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd3)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ov_reg <= '0;
            un_reg <= '0;
        end
        else if (busy_reg)
        begin
            ov_reg <= ov_reg + 7'(ov_s);
            un_reg <= un_reg + 7'(un_s);
        end
    end

    // The totals hold from the cycle after done until the next start.
    assign done      = busy_reg && (step_reg == 3'd3);
    assign overlap   = ov_reg;
    assign union_cnt = un_reg;
endmodule
`default_nettype wire

>>> rtl/core/region_transition_pattern_table_top.sv
// Region transition pattern table, top level.
// Depends on rtpt_pkg and rtpt_popcnt.
//
// Usage: one word in on the input channel (kind, three 6-bit offsets and two
// new patterns) gives exactly one word out. Input and output use valid and
// stall; a word moves at an edge with valid high and stall low.
// Configuration writes (index 0 max_confidence, 1 use_threshold) use
// cfg_valid/cfg_ready and are always ready.
// Each word is handled in turn by a small sequencer. The set is searched
// one way per cycle; then the target entry is fetched and, for an update or
// a penalize hit, written back, and an update or a lookup hit promotes it
// in the LRU row before out_valid rises. An update that hits also passes
// through the bit counter (16 blocks a cycle) between fetch and write. A
// new word is taken only once the last result has left the output.
// While a word is in work, or its result waits on a stalled receiver,
// in_stall stays high; the result register holds steady under out_stall.
// Reset clears all valid bits and sets each entry's LRU rank to its way
// index; no clearing pass is needed. Registers return to 3 and 2.
// The key modulo the set count selects the set.
`timescale 1ns / 1ps
`default_nettype none
module region_transition_pattern_table_top
    import rtpt_pkg::*;
#(
    parameter int TABLE_ENTRIES = RTPT_ENTRIES,
    parameter int TABLE_WAYS    = RTPT_WAYS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [5:0]  last_trigger,
    input  wire logic [5:0]  cur_trigger,
    input  wire logic [5:0]  cur_second,
    input  wire logic [63:0] new_l1_mask,
    input  wire logic [63:0] new_l2_mask,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             hit,
    output logic [3:0]       confidence,
    output logic             usable,
    output logic [63:0]      out_l1_mask,
    output logic [63:0]      out_l2_mask,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data
);
    localparam int SETS   = TABLE_ENTRIES / TABLE_WAYS;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int WCNT_W = $clog2(TABLE_WAYS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_COUNT = 3'd4;
    localparam logic [2:0] ST_WRITE = 3'd5;
    localparam logic [2:0] ST_LRU   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // Entry storage: separate arrays for key, confidence and both patterns. Valid
    // bits and LRU ranks are kept one row per set, and a word touches a single row.
    logic [KEY_W-1:0]  key_mem  [TABLE_ENTRIES];
    logic [CONF_W-1:0] conf_mem [TABLE_ENTRIES];
    logic [63:0]       l1_mem   [TABLE_ENTRIES];
    logic [63:0]       l2_mem   [TABLE_ENTRIES];
    logic [TABLE_WAYS-1:0]            valid_reg [SETS];
    logic [TABLE_WAYS-1:0][WAY_W-1:0] rank_reg  [SETS];
    logic [TABLE_WAYS-1:0]            set_valid;
    logic [TABLE_WAYS-1:0][WAY_W-1:0] set_rank, rank_next;

    logic [2:0]        state_reg;
    logic [1:0]        kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [63:0]       n1_reg, n2_reg;
    logic [SET_W-1:0]  set_reg;
    logic [WCNT_W-1:0] way_reg;
    logic              hit_reg;
    logic [WAY_W-1:0]  hway_reg, victim_reg, worst_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [CONF_W-1:0] rd_conf_reg;
    logic [63:0]       rd_l1_reg, rd_l2_reg;
    logic              rd_valid_reg;
    logic [WAY_W-1:0]  rd_way_reg;
    logic [3:0]        max_conf_reg, thresh_reg;

    logic              o_hit_reg, o_usable_reg;
    logic [3:0]        o_conf_reg;
    logic [63:0]       o_l1_reg, o_l2_reg;

    logic              pc_start, pc_done;
    logic [6:0]        pc_ov, pc_un;
    logic [63:0]       old_any;
    logic [IDX_W-1:0]  tgt_idx;
    logic [WAY_W-1:0]  tgt_way;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign hit         = o_hit_reg;
    assign confidence  = o_conf_reg;
    assign usable      = o_usable_reg;
    assign out_l1_mask = o_l1_reg;
    assign out_l2_mask = o_l2_reg;

    function automatic logic [IDX_W-1:0] ent_idx(input logic [SET_W-1:0] s,
                                                 input logic [WAY_W-1:0] w);
        logic [IDX_W+WAY_W+SET_W-1:0] t;
        begin
            t = (IDX_W+WAY_W+SET_W)'(s) * (IDX_W+WAY_W+SET_W)'(TABLE_WAYS)
                + (IDX_W+WAY_W+SET_W)'(w);
            return t[IDX_W-1:0];
        end
    endfunction

    assign tgt_way = hit_reg ? hway_reg : victim_reg;
    assign tgt_idx = ent_idx(set_reg, tgt_way);
    // The target entry stays addressed while the bit counter runs.
    assign rd_addr = (state_reg == ST_FETCH || state_reg == ST_COUNT) ? tgt_idx
                     : ent_idx(set_reg, way_reg[WAY_W-1:0]);
    assign old_any = rd_l1_reg | rd_l2_reg;
    assign pc_start = (state_reg == ST_FETCH) && rd_valid_reg;

    assign set_valid = valid_reg[set_reg];
    assign set_rank  = rank_reg[set_reg];

    // Promoted rank row: ways younger than the touched one age by one.
    always_comb
    begin
        for (int w = 0; w < TABLE_WAYS; w++)
        begin
            if (set_rank[w] < set_rank[tgt_way])
                rank_next[w] = set_rank[w] + WAY_W'(1);
            else
                rank_next[w] = set_rank[w];
        end
        rank_next[tgt_way] = '0;
    end

    rtpt_popcnt u_popcnt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pc_start),
        .a         (old_any),
        .b         (n1_reg | n2_reg),
        .done      (pc_done),
        .overlap   (pc_ov),
        .union_cnt (pc_un)
    );

    // Registered memory read, one address per cycle.
    always_ff @(posedge clk)
    begin
        rd_key_reg  <= key_mem[rd_addr];
        rd_conf_reg <= conf_mem[rd_addr];
        rd_l1_reg   <= l1_mem[rd_addr];
        rd_l2_reg   <= l2_mem[rd_addr];
        rd_way_reg  <= way_reg[WAY_W-1:0];
    end

    // Write-back values for an update.
    logic              similar;
    logic [CONF_W-1:0] wr_conf;
    logic [63:0]       wr_l1, wr_l2, merged_l1;
    always_comb
    begin
        similar   = (pc_un == 7'd0) || ({pc_ov, 1'b0} >= {1'b0, pc_un});
        merged_l1 = rd_l1_reg | n1_reg;
        wr_conf   = 4'd1;
        wr_l1     = n1_reg;
        wr_l2     = n2_reg;
        if (hit_reg)
        begin
            if (similar)
            begin
                wr_conf = (rd_conf_reg < max_conf_reg) ? rd_conf_reg + 4'd1
                                                       : rd_conf_reg;
                wr_l1 = merged_l1;
                wr_l2 = (rd_l2_reg | (n2_reg & ~old_any)) & ~merged_l1;
            end
            else
            begin
                wr_conf = (rd_conf_reg != 4'd0) ? rd_conf_reg - 4'd1 : 4'd0;
                wr_l1 = (wr_conf == 4'd0) ? n1_reg : rd_l1_reg;
                wr_l2 = (wr_conf == 4'd0) ? n2_reg : rd_l2_reg;
            end
        end
    end

    logic do_write;
    assign do_write = (state_reg == ST_WRITE);

    // Only an update or a penalize that hits changes an entry.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            if (kind_reg == KIND_UPDATE)
            begin
                key_mem[tgt_idx]  <= key_reg;
                conf_mem[tgt_idx] <= wr_conf;
                l1_mem[tgt_idx]   <= wr_l1;
                l2_mem[tgt_idx]   <= wr_l2;
            end
            else if (kind_reg == KIND_PENALIZE && hit_reg)
            begin
                conf_mem[tgt_idx] <= (rd_conf_reg != 4'd0) ? rd_conf_reg - 4'd1
                                                           : 4'd0;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            max_conf_reg <= MAX_CONF_RST;
            thresh_reg   <= THRESHOLD_RST;
            rd_valid_reg <= 1'b0;
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
                for (int w = 0; w < TABLE_WAYS; w++)
                    rank_reg[s][w] <= WAY_W'(w);
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MAX_CONF)
                    max_conf_reg <= cfg_data;
                else
                    thresh_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_READ;
                        way_reg   <= '0;
                        hit_reg   <= 1'b0;
                        free_reg  <= 1'b0;
                        worst_reg <= '0;
                        victim_reg <= '0;
                    end
                end
                ST_READ:
                begin
                    way_reg   <= way_reg + WCNT_W'(1);
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (!hit_reg && set_valid[rd_way_reg] && rd_key_reg == key_reg)
                    begin
                        hit_reg  <= 1'b1;
                        hway_reg <= rd_way_reg;
                    end
                    if (!free_reg)
                    begin
                        if (!set_valid[rd_way_reg])
                        begin
                            free_reg   <= 1'b1;
                            victim_reg <= rd_way_reg;
                        end
                        else if (set_rank[rd_way_reg] >= worst_reg)
                        begin
                            worst_reg  <= set_rank[rd_way_reg];
                            victim_reg <= rd_way_reg;
                        end
                    end
                    if (way_reg == WCNT_W'(TABLE_WAYS))
                        state_reg <= ST_FETCH;
                    else
                        way_reg <= way_reg + WCNT_W'(1);
                end
                ST_FETCH:
                begin
                    rd_valid_reg <= !rd_valid_reg;
                    if (rd_valid_reg)
                    begin
                        if (kind_reg == KIND_UPDATE && hit_reg)
                            state_reg <= ST_COUNT;
                        else
                            state_reg <= ST_WRITE;
                    end
                end
                ST_COUNT:
                begin
                    if (pc_done)
                        state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    state_reg <= ST_LRU;
                    o_hit_reg <= hit_reg && (kind_reg != KIND_UNUSED);
                    o_usable_reg <= 1'b0;
                    o_conf_reg <= '0;
                    o_l1_reg   <= '0;
                    o_l2_reg   <= '0;
                    if (kind_reg == KIND_UPDATE)
                    begin
                        valid_reg[set_reg][tgt_way] <= 1'b1;
                        o_conf_reg <= wr_conf;
                        o_l1_reg   <= wr_l1;
                        o_l2_reg   <= wr_l2;
                    end
                    else if (hit_reg && kind_reg == KIND_LOOKUP)
                    begin
                        o_conf_reg   <= rd_conf_reg;
                        o_usable_reg <= rd_conf_reg >= thresh_reg;
                        o_l1_reg     <= rd_l1_reg;
                        o_l2_reg     <= rd_l2_reg;
                    end
                    else if (hit_reg && kind_reg == KIND_PENALIZE)
                    begin
                        o_conf_reg <= (rd_conf_reg != 4'd0) ? rd_conf_reg - 4'd1
                                                            : 4'd0;
                        o_l1_reg   <= rd_l1_reg;
                        o_l2_reg   <= rd_l2_reg;
                    end
                end
                ST_LRU:
                begin
                    // For an update or a lookup hit, promote the touched way; the set's rank row is written once.
                    if (kind_reg == KIND_UPDATE ||
                        (kind_reg == KIND_LOOKUP && hit_reg))
                        rank_reg[set_reg] <= rank_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_stall)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Captured word; payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            kind_reg <= kind;
            key_reg  <= {last_trigger, cur_trigger, cur_second};
            set_reg  <= SET_W'({last_trigger, cur_trigger, cur_second} % SETS);
            n1_reg   <= new_l1_mask;
            n2_reg   <= new_l2_mask & ~new_l1_mask;
        end
    end

    // A result is shown only after a word has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_LRU)
        else $error("result without completed sequence");
    // The l1 pattern and confidence outputs are stable while held under stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(o_l1_reg) && $stable(o_conf_reg))
        else $error("result changed under stall");
    // Usable only on a lookup hit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && usable |-> hit && kind_reg == KIND_LOOKUP)
        else $error("usable without lookup hit");
endmodule
`default_nettype wire
